[hdl/ssg_pkg.sv]
// Shared types and constants for the siren sweep generator.
// Used by ssg_regs, ssg_core and siren_sweep_generator_unit.
package ssg_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_ONCE  = 2'd2,
        OP_STOP  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        REG_ENABLED      = 3'd0,
        REG_PASSIVE_MODE = 3'd1,
        REG_MIN_FREQ     = 3'd2,
        REG_MAX_FREQ     = 3'd3,
        REG_FREQ_STEP    = 3'd4,
        REG_SWEEP_IVL    = 3'd5,
        REG_ONCE_DUR     = 3'd6,
        REG_UNUSED       = 3'd7
    } t_reg_idx;

    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    localparam logic        RST_ENABLED      = 1'b1;
    localparam logic        RST_PASSIVE_MODE = 1'b1;
    localparam logic [15:0] RST_MIN_FREQ     = 16'd1000;
    localparam logic [15:0] RST_MAX_FREQ     = 16'd3000;
    localparam logic [15:0] RST_FREQ_STEP    = 16'd50;
    localparam logic [15:0] RST_SWEEP_IVL    = 16'd10;
    localparam logic [31:0] RST_ONCE_DUR     = 32'd3000;

    // Active buzzer toggle period
    localparam logic [31:0] PIN_TOGGLE_MS    = 32'd150;

    typedef struct packed {
        logic        enabled;
        logic        passive_mode;
        logic [15:0] min_freq_hz;
        logic [15:0] max_freq_hz;
        logic [15:0] freq_step_hz;
        logic [15:0] sweep_interval_ms;
        logic [31:0] once_duration_ms;
    } t_cfg;

    typedef struct packed {
        logic        siren_active;
        logic        tone_on;
        logic [15:0] tone_hz;
        logic        pin_level;
    } t_result;

endpackage

[hdl/ssg_regs.sv]
// APB-style configuration register file for the siren sweep generator.
// Depends on ssg_pkg for register indexes, reset values and t_cfg.
module ssg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ssg_pkg::ADDR_W-1:0]  paddr,
    input  logic [ssg_pkg::DATA_W-1:0]  pwdata,
    output logic [ssg_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output ssg_pkg::t_cfg               o_cfg,
    output logic                        o_halt
);

    ssg_pkg::t_cfg      r_cfg;
    ssg_pkg::t_cfg      n_cfg;
    logic               wr_en;
    ssg_pkg::t_reg_idx  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = ssg_pkg::t_reg_idx'(paddr[ssg_pkg::ADDR_W-1:2]);

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                ssg_pkg::REG_ENABLED:      n_cfg.enabled           = pwdata[0];
                ssg_pkg::REG_PASSIVE_MODE: n_cfg.passive_mode      = pwdata[0];
                ssg_pkg::REG_MIN_FREQ:     n_cfg.min_freq_hz       = pwdata[15:0];
                ssg_pkg::REG_MAX_FREQ:     n_cfg.max_freq_hz       = pwdata[15:0];
                ssg_pkg::REG_FREQ_STEP:    n_cfg.freq_step_hz      = pwdata[15:0];
                ssg_pkg::REG_SWEEP_IVL:    n_cfg.sweep_interval_ms = pwdata[15:0];
                ssg_pkg::REG_ONCE_DUR:     n_cfg.once_duration_ms  = pwdata[31:0];
                default: ;
            endcase
        end
    end

    // Writing enabled as 0 stops a running siren
    assign o_halt = wr_en && (reg_idx == ssg_pkg::REG_ENABLED) && !pwdata[0];

    always_comb begin
        case (reg_idx)
            ssg_pkg::REG_ENABLED:      prdata = {31'd0, r_cfg.enabled};
            ssg_pkg::REG_PASSIVE_MODE: prdata = {31'd0, r_cfg.passive_mode};
            ssg_pkg::REG_MIN_FREQ:     prdata = {16'd0, r_cfg.min_freq_hz};
            ssg_pkg::REG_MAX_FREQ:     prdata = {16'd0, r_cfg.max_freq_hz};
            ssg_pkg::REG_FREQ_STEP:    prdata = {16'd0, r_cfg.freq_step_hz};
            ssg_pkg::REG_SWEEP_IVL:    prdata = {16'd0, r_cfg.sweep_interval_ms};
            ssg_pkg::REG_ONCE_DUR:     prdata = r_cfg.once_duration_ms;
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enabled           <= ssg_pkg::RST_ENABLED;
            r_cfg.passive_mode      <= ssg_pkg::RST_PASSIVE_MODE;
            r_cfg.min_freq_hz       <= ssg_pkg::RST_MIN_FREQ;
            r_cfg.max_freq_hz       <= ssg_pkg::RST_MAX_FREQ;
            r_cfg.freq_step_hz      <= ssg_pkg::RST_FREQ_STEP;
            r_cfg.sweep_interval_ms <= ssg_pkg::RST_SWEEP_IVL;
            r_cfg.once_duration_ms  <= ssg_pkg::RST_ONCE_DUR;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hdl/ssg_core.sv]
// Siren state registers and the single-pass event update (start, once, stop, halt, sweep, toggle, expiry).
// Depends on ssg_pkg for t_op, t_cfg, t_result and PIN_TOGGLE_MS.
module ssg_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ssg_pkg::t_cfg    i_cfg,
    input  logic             i_halt,
    input  logic             i_fire,
    input  ssg_pkg::t_op     i_op,
    input  logic [31:0]      i_now_ms,
    output ssg_pkg::t_result o_result
);

    logic        r_running,      n_running;
    logic        r_once_mode,    n_once_mode;
    logic [31:0] r_once_start,   n_once_start;
    logic [31:0] r_last_update,  n_last_update;
    logic [15:0] r_freq_now,     n_freq_now;
    logic        r_sweep_down,   n_sweep_down;
    logic        r_buzz_level,   n_buzz_level;
    logic        r_tone_driving, n_tone_driving;

    logic [31:0]        since_last;
    logic [31:0]        since_once;
    logic               sweep_gated;
    logic               pin_gated;
    logic               once_expired;
    logic signed [17:0] sweep_sum;
    logic signed [17:0] max_ext;
    logic signed [17:0] min_ext;

    assign since_last   = i_now_ms - r_last_update;
    assign since_once   = i_now_ms - r_once_start;
    assign sweep_gated  = (r_last_update != 32'd0) &&
                          (since_last < {16'd0, i_cfg.sweep_interval_ms});
    assign pin_gated    = (r_last_update != 32'd0) && (since_last < ssg_pkg::PIN_TOGGLE_MS);
    assign once_expired = r_once_mode && (since_once >= i_cfg.once_duration_ms);

    assign max_ext   = $signed({2'b00, i_cfg.max_freq_hz});
    assign min_ext   = $signed({2'b00, i_cfg.min_freq_hz});
    assign sweep_sum = r_sweep_down ?
                       $signed({2'b00, r_freq_now}) - $signed({2'b00, i_cfg.freq_step_hz}) :
                       $signed({2'b00, r_freq_now}) + $signed({2'b00, i_cfg.freq_step_hz});

    always_comb begin
        n_running      = r_running;
        n_once_mode    = r_once_mode;
        n_once_start   = r_once_start;
        n_last_update  = r_last_update;
        n_freq_now     = r_freq_now;
        n_sweep_down   = r_sweep_down;
        n_buzz_level   = r_buzz_level;
        n_tone_driving = r_tone_driving;
        if (i_halt) begin
            n_running      = 1'b0;
            n_once_mode    = 1'b0;
            n_buzz_level   = 1'b0;
            n_tone_driving = 1'b0;
        end else if (i_fire) begin
            case (i_op)
                ssg_pkg::OP_TICK: begin
                    if (r_running && i_cfg.enabled) begin
                        if (once_expired) begin
                            n_running      = 1'b0;
                            n_once_mode    = 1'b0;
                            n_buzz_level   = 1'b0;
                            n_tone_driving = 1'b0;
                        end else if (i_cfg.passive_mode) begin
                            if (!sweep_gated) begin
                                // Max test first: if the sum meets both bounds (min above max), max wins
                                if (sweep_sum >= max_ext) begin
                                    n_freq_now   = i_cfg.max_freq_hz;
                                    n_sweep_down = 1'b1;
                                end else if (sweep_sum <= min_ext) begin
                                    n_freq_now   = i_cfg.min_freq_hz;
                                    n_sweep_down = 1'b0;
                                end else begin
                                    n_freq_now   = sweep_sum[15:0];
                                end
                                n_tone_driving = 1'b1;
                                n_last_update  = i_now_ms;
                            end
                        end else if (!pin_gated) begin
                            n_buzz_level  = !r_buzz_level;
                            n_last_update = i_now_ms;
                        end
                    end
                end
                ssg_pkg::OP_START: begin
                    if (!i_cfg.enabled) begin
                        n_running      = 1'b0;
                        n_buzz_level   = 1'b0;
                        n_tone_driving = 1'b0;
                    end else begin
                        n_running      = 1'b1;
                    end
                    n_once_mode = 1'b0;
                end
                ssg_pkg::OP_ONCE: begin
                    if (!i_cfg.enabled) begin
                        n_running      = 1'b0;
                        n_once_mode    = 1'b0;
                        n_buzz_level   = 1'b0;
                        n_tone_driving = 1'b0;
                    end else begin
                        n_running    = 1'b1;
                        n_once_mode  = 1'b1;
                        n_once_start = i_now_ms;
                    end
                end
                default: begin
                    n_running      = 1'b0;
                    n_once_mode    = 1'b0;
                    n_buzz_level   = 1'b0;
                    n_tone_driving = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running      <= 1'b0;
            r_once_mode    <= 1'b0;
            r_once_start   <= 32'd0;
            r_last_update  <= 32'd0;
            r_freq_now     <= ssg_pkg::RST_MIN_FREQ;
            r_sweep_down   <= 1'b0;
            r_buzz_level   <= 1'b0;
            r_tone_driving <= 1'b0;
        end else begin
            r_running      <= n_running;
            r_once_mode    <= n_once_mode;
            r_once_start   <= n_once_start;
            r_last_update  <= n_last_update;
            r_freq_now     <= n_freq_now;
            r_sweep_down   <= n_sweep_down;
            r_buzz_level   <= n_buzz_level;
            r_tone_driving <= n_tone_driving;
        end
    end

    // Result reflects the state after this event
    assign o_result.siren_active = n_running;
    assign o_result.tone_on      = n_tone_driving;
    assign o_result.tone_hz      = n_freq_now;
    assign o_result.pin_level    = n_buzz_level;

endmodule

[hdl/siren_sweep_generator_unit.sv]
// Siren sweep generator top level: input register, event core, result register.
// Depends on ssg_pkg, ssg_regs and ssg_core.
//
// Usage:
//   Events enter on the input channel (i_in_valid / o_in_ready, payload i_op and
//   i_now_ms) and each produces exactly one result on the output channel
//   (o_out_valid / i_out_ready, payload o_siren_active, o_tone_on, o_tone_hz,
//   o_pin_level) giving the siren state after that event.
//   Events wait in the input register; results are held in the result register.
//   Throughput: one event per cycle unless stalled; the input register feeds the
//   core and the result register in a single pass, so that one stage sets the rate.
//   When the receiver stalls, the result register holds and the input register
//   keeps one more event; the input side stalls only when both are full.
//   Reset (i_rst_n low, synchronous) empties both registers, stops the siren,
//   sets the sweep to the minimum frequency going upward and loads the
//   configuration registers with their defaults.
//   Configuration goes through the APB-style port (pready always high) and must be
//   written only while no transaction is in flight; the block does not enforce it.
module siren_sweep_generator_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_op,
    input  logic [31:0]                 i_now_ms,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_siren_active,
    output logic                        o_tone_on,
    output logic [15:0]                 o_tone_hz,
    output logic                        o_pin_level,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ssg_pkg::ADDR_W-1:0]  paddr,
    input  logic [ssg_pkg::DATA_W-1:0]  pwdata,
    output logic [ssg_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    ssg_pkg::t_cfg    cfg;
    logic             cfg_halt;
    ssg_pkg::t_result core_result;

    logic             r_in_valid;
    ssg_pkg::t_op     r_op;
    logic [31:0]      r_now_ms;
    logic             r_out_valid;
    ssg_pkg::t_result r_result;
    logic             fire;
    logic             in_take;

    // Advance when the result register is empty or being drained
    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;
    assign in_take    = i_in_valid && o_in_ready;

    ssg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg),
        .o_halt  (cfg_halt)
    );

    ssg_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_halt   (cfg_halt),
        .i_fire   (fire),
        .i_op     (r_op),
        .i_now_ms (r_now_ms),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op     <= ssg_pkg::t_op'(i_op);
            r_now_ms <= i_now_ms;
        end
        if (fire) begin
            r_result <= core_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_siren_active = r_result.siren_active;
    assign o_tone_on      = r_result.tone_on;
    assign o_tone_hz      = r_result.tone_hz;
    assign o_pin_level    = r_result.pin_level;

endmodule

[hdl/ssg_checker.sv]
// Port-level checks for siren_sweep_generator_unit, attached by bind.
// Depends only on the top level's ports.
module ssg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_siren_active,
    input logic        o_tone_on,
    input logic [15:0] o_tone_hz,
    input logic        o_pin_level
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_tone_hz))
        else $error("stalled result dropped or changed");

    // With the result slot empty the input side must not stall
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

    // A stopped siren drives neither tone nor pin
    a_stopped_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_siren_active |-> !o_tone_on && !o_pin_level)
        else $error("tone or pin active while siren stopped");

    // Nothing comes out in the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind siren_sweep_generator_unit ssg_checker u_ssg_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_siren_active (o_siren_active),
    .o_tone_on      (o_tone_on),
    .o_tone_hz      (o_tone_hz),
    .o_pin_level    (o_pin_level)
);
